// File: rtl/bda_pkg.sv
`timescale 1ns / 1ps

package bda_pkg;

  // Width of the internal time arithmetic; all elapsed-time math wraps at this width.
  localparam int TIME_BITS = 32;

  // Fixed widths of the channel and configuration fields.
  localparam int TS_W    = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX = 2;
  localparam int EV_W    = 2;

  typedef logic [TIME_BITS-1:0] tstamp_t;
  typedef logic [CFG_W-1:0]     msec_t;
  typedef logic [EV_W-1:0]      event_t;
  typedef logic [CFG_IDX-1:0]   cfg_idx_t;

  // Event codes on the result channel.
  localparam event_t EV_NONE     = 2'd0;
  localparam event_t EV_PRESSED  = 2'd1;
  localparam event_t EV_RELEASED = 2'd2;
  localparam event_t EV_REPEAT   = 2'd3;

  // Configuration register indexes.
  localparam cfg_idx_t REG_REPEAT_ENABLE     = 2'd0;
  localparam cfg_idx_t REG_DEBOUNCE_INTERVAL = 2'd1;
  localparam cfg_idx_t REG_REPEAT_DELAY      = 2'd2;
  localparam cfg_idx_t REG_REPEAT_INTERVAL   = 2'd3;

  // Reset values of the configuration registers.
  localparam msec_t DEBOUNCE_RST     = 16'd20;
  localparam msec_t REPEAT_DELAY_RST = 16'd500;
  localparam msec_t REPEAT_IVL_RST   = 16'd100;

  // Current configuration as seen by the event logic.
  typedef struct packed {
    logic  repeat_enable;
    msec_t debounce_interval;
    msec_t repeat_delay;
    msec_t repeat_interval;
  } cfg_t;

  // Map the 32-bit timestamp onto the internal time width (truncate or zero-extend).
  function automatic tstamp_t to_tstamp(input logic [TS_W-1:0] ts);
    tstamp_t r;
    for (int i = 0; i < TIME_BITS; i++) begin
      r[i] = (i < TS_W) ? ts[i % TS_W] : 1'b0;
    end
    return r;
  endfunction

endpackage

// File: rtl/bda_in_if.sv
`timescale 1ns / 1ps

// Sample channel: one raw button level and its timestamp per beat.
interface bda_in_if;
  logic                      valid;
  logic                      ready;
  logic                      raw_level;
  logic [bda_pkg::TS_W-1:0]  timestamp;

  modport source (output valid, output raw_level, output timestamp, input ready);
  modport sink   (input valid, input raw_level, input timestamp, output ready);
endinterface

// Event channel: one event code per beat.
interface bda_out_if;
  logic                 valid;
  logic                 ready;
  bda_pkg::event_t      event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

// File: rtl/button_debounce_autorepeat.sv
`timescale 1ns / 1ps

// Button debounce with auto-repeat.
// in_s carries one sample per beat: the raw button level (1 = pressed) and a
// wrapping millisecond timestamp. out_s returns exactly one event per sample:
// none, pressed, released or repeat, in sample order.
// cfg_we/cfg_index/cfg_wdata write the repeat enable (0), debounce interval (1),
// repeat delay (2) and repeat interval (3); write them only while no sample is
// in flight.
// A sample is taken into an input register, its event is formed by one pass of
// compare and add logic on the debounce state, and the event sits in an output
// register. out_s.valid rises when the sample moves on from the input register,
// which it does only once the output register is empty or being drained.
// Throughput is one sample per cycle while the receiver keeps out_s.ready high;
// the limit is the single state update per sample in the event logic.
// When the receiver stalls, the output register holds its event and the input
// register still takes one more sample; further samples wait on in_s.ready.
// Reset (rst_n low at a clock edge) empties both registers, clears the debounce
// state to released, and restores the configuration to its defaults.
module button_debounce_autorepeat (
  input  logic                      clk,
  input  logic                      rst_n,
  bda_in_if.sink                    in_s,
  bda_out_if.source                 out_s,
  input  logic                      cfg_we,
  input  bda_pkg::cfg_idx_t         cfg_index,
  input  logic [bda_pkg::CFG_W-1:0] cfg_wdata
);

  bda_pkg::cfg_t    cfg;
  logic             s1_valid_r;
  logic             s1_level_r;
  bda_pkg::tstamp_t s1_time_r;
  logic             out_valid_r;
  bda_pkg::event_t  out_code_r;
  logic             adv;
  logic             in_take;
  bda_pkg::event_t  ev;
  logic             stable_level;

  bda_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The sample advances when the output register is empty or being drained.
  assign adv        = s1_valid_r && (!out_valid_r || out_s.ready);
  assign in_s.ready = !s1_valid_r || adv;
  assign in_take    = in_s.valid && in_s.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level_r <= in_s.raw_level;
      s1_time_r  <= bda_pkg::to_tstamp(in_s.timestamp);
    end
  end

  bda_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .level        (s1_level_r),
    .now          (s1_time_r),
    .cfg          (cfg),
    .event_code   (ev),
    .stable_level (stable_level)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_code_r <= ev;
    end
  end

  assign out_s.valid      = out_valid_r;
  assign out_s.event_code = out_code_r;

  // An empty input register always takes a sample.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_s.ready)
    else $error("input register empty but not ready");

  // A full pipeline with a stalled receiver keeps its pending sample.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_s.ready) |=> s1_valid_r)
    else $error("pending sample lost during stall");

  // A press event leaves the stable level pressed; a release leaves it released.
  a_press: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ev == bda_pkg::EV_PRESSED) |=> stable_level)
    else $error("press event without stable press");

  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ev == bda_pkg::EV_RELEASED) |=> !stable_level)
    else $error("release event without stable release");

  // Repeats fire only while stably pressed with repeat enabled.
  a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ev == bda_pkg::EV_REPEAT) |-> (stable_level && cfg.repeat_enable))
    else $error("repeat event while not held or repeat disabled");

endmodule

// File: rtl/bda_cfg_regs.sv
`timescale 1ns / 1ps

module bda_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  bda_pkg::cfg_idx_t         cfg_index,
  input  logic [bda_pkg::CFG_W-1:0] cfg_wdata,
  output bda_pkg::cfg_t             cfg
);

  logic           repeat_enable_r;
  bda_pkg::msec_t debounce_interval_r;
  bda_pkg::msec_t repeat_delay_r;
  bda_pkg::msec_t repeat_interval_r;

  // Register file with write-only access; every index of the port is a known register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_enable_r     <= 1'b0;
      debounce_interval_r <= bda_pkg::DEBOUNCE_RST;
      repeat_delay_r      <= bda_pkg::REPEAT_DELAY_RST;
      repeat_interval_r   <= bda_pkg::REPEAT_IVL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bda_pkg::REG_REPEAT_ENABLE:     repeat_enable_r     <= cfg_wdata[0];
        bda_pkg::REG_DEBOUNCE_INTERVAL: debounce_interval_r <= cfg_wdata;
        bda_pkg::REG_REPEAT_DELAY:      repeat_delay_r      <= cfg_wdata;
        bda_pkg::REG_REPEAT_INTERVAL:   repeat_interval_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.repeat_enable     = repeat_enable_r;
  assign cfg.debounce_interval = debounce_interval_r;
  assign cfg.repeat_delay      = repeat_delay_r;
  assign cfg.repeat_interval   = repeat_interval_r;

endmodule

// File: rtl/bda_core.sv
`timescale 1ns / 1ps

module bda_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             level,
  input  bda_pkg::tstamp_t now,
  input  bda_pkg::cfg_t    cfg,
  output bda_pkg::event_t  event_code,
  output logic             stable_level
);

  logic             cand_level_r;
  bda_pkg::tstamp_t cand_start_r;
  logic             stable_level_r;
  bda_pkg::tstamp_t deadline_r;

  logic             cand_level_nxt;
  bda_pkg::tstamp_t cand_start_nxt;
  logic             stable_level_nxt;
  bda_pkg::tstamp_t deadline_nxt;

  bda_pkg::tstamp_t elapsed;
  bda_pkg::tstamp_t to_deadline;
  logic             held;
  logic             due;

  // A new raw level restarts the candidate timer at the current sample.
  assign cand_level_nxt = level;
  assign cand_start_nxt = (level != cand_level_r) ? now : cand_start_r;

  // Wrapped elapsed time against the debounce interval, and the deadline sign test.
  assign elapsed     = now - cand_start_nxt;
  assign held        = elapsed >= bda_pkg::TIME_BITS'(cfg.debounce_interval);
  assign to_deadline = now - deadline_r;
  assign due         = !to_deadline[bda_pkg::TIME_BITS-1];

  // An accepted level change takes priority over a repeat.
  always_comb begin
    stable_level_nxt = stable_level_r;
    deadline_nxt     = deadline_r;
    event_code       = bda_pkg::EV_NONE;
    priority if ((stable_level_r != level) && held) begin
      stable_level_nxt = level;
      if (level) begin
        if (cfg.repeat_enable) begin
          deadline_nxt = now + bda_pkg::TIME_BITS'(cfg.repeat_delay);
        end
        event_code = bda_pkg::EV_PRESSED;
      end else begin
        event_code = bda_pkg::EV_RELEASED;
      end
    end else if (stable_level_r && cfg.repeat_enable && due) begin
      deadline_nxt = now + bda_pkg::TIME_BITS'(cfg.repeat_interval);
      event_code   = bda_pkg::EV_REPEAT;
    end else begin
      event_code = bda_pkg::EV_NONE;
    end
  end

  // State moves only when the sample leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_level_r   <= 1'b0;
      cand_start_r   <= '0;
      stable_level_r <= 1'b0;
      deadline_r     <= '0;
    end else if (adv) begin
      cand_level_r   <= cand_level_nxt;
      cand_start_r   <= cand_start_nxt;
      stable_level_r <= stable_level_nxt;
      deadline_r     <= deadline_nxt;
    end
  end

  assign stable_level = stable_level_r;

endmodule
